// ===== rtl/nreg_pkg.sv =====
// ----------------------------------------------------------------------------
// Name registry package
// Sizes, codes, state encoding and the controller/datapath interface types
// shared by the name registry table modules.
// ----------------------------------------------------------------------------
package nreg_pkg;

  localparam int ENTRIES        = 64;
  localparam int MAX_NAME_CHARS = 63;

  localparam int CHAR_W   = 8;
  localparam int ID_W     = 6;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  localparam int ENTRY_W    = $clog2(ENTRIES);
  localparam int USED_W     = $clog2(ENTRIES + 1);
  localparam int IDX_W      = $clog2(MAX_NAME_CHARS);
  localparam int LEN_W      = $clog2(MAX_NAME_CHARS + 1);
  localparam int NAME_DEPTH = ENTRIES * (2 ** IDX_W);

  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_BAD_REQ   = 3'd3,
    STAT_TOO_LONG  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LEN_RD,
    S_LEN_CHK,
    S_CH_RD,
    S_CH_CHK,
    S_HIT,
    S_MISS,
    S_ID_RD,
    S_ID_CHK,
    S_CP_RD,
    S_CP_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    name_clr;
    logic    e_clr;
    logic    e_inc;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_len;
    logic    rd_chars;
    logic    rd_id;
    logic    wr_id_hit;
    logic    wr_name;
    logic    commit_new;
    logic    res_clr;
    logic    res_set;
    status_t res_code;
    logic    res_found_ld;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic req_bad;
    logic req_lookup;
    logic too_long;
    logic used_zero;
    logic full;
    logic len_eq;
    logic char_eq;
    logic idx_last;
    logic e_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/nreg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Name registry controller
// Sequences collection, entry search, update or append and result hand-off.
// ----------------------------------------------------------------------------
module nreg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_char,
  output logic              in_stall,
  input  nreg_pkg::dp_stat_t stat,
  output nreg_pkg::dp_cmd_t  cmd
);

  nreg_pkg::state_t state_r;
  nreg_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nreg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nreg_pkg::S_IDLE: begin
        if (in_valid && in_last_char) begin
          state_nxt = nreg_pkg::S_CHECK;
        end
      end
      nreg_pkg::S_CHECK: begin
        if (stat.req_bad || stat.too_long) begin
          state_nxt = nreg_pkg::S_DONE;
        end else if (stat.used_zero) begin
          state_nxt = nreg_pkg::S_MISS;
        end else begin
          state_nxt = nreg_pkg::S_LEN_RD;
        end
      end
      nreg_pkg::S_LEN_RD: state_nxt = nreg_pkg::S_LEN_CHK;
      nreg_pkg::S_LEN_CHK: begin
        if (stat.len_eq) begin
          state_nxt = nreg_pkg::S_CH_RD;
        end else if (stat.e_last) begin
          state_nxt = nreg_pkg::S_MISS;
        end else begin
          state_nxt = nreg_pkg::S_LEN_RD;
        end
      end
      nreg_pkg::S_CH_RD: state_nxt = nreg_pkg::S_CH_CHK;
      nreg_pkg::S_CH_CHK: begin
        if (!stat.char_eq) begin
          state_nxt = stat.e_last ? nreg_pkg::S_MISS : nreg_pkg::S_LEN_RD;
        end else if (stat.idx_last) begin
          state_nxt = nreg_pkg::S_HIT;
        end else begin
          state_nxt = nreg_pkg::S_CH_RD;
        end
      end
      nreg_pkg::S_HIT: begin
        state_nxt = stat.req_lookup ? nreg_pkg::S_ID_RD : nreg_pkg::S_DONE;
      end
      nreg_pkg::S_ID_RD:  state_nxt = nreg_pkg::S_ID_CHK;
      nreg_pkg::S_ID_CHK: state_nxt = nreg_pkg::S_DONE;
      nreg_pkg::S_MISS: begin
        if (stat.req_lookup || stat.full) begin
          state_nxt = nreg_pkg::S_DONE;
        end else begin
          state_nxt = nreg_pkg::S_CP_RD;
        end
      end
      nreg_pkg::S_CP_RD: state_nxt = nreg_pkg::S_CP_WR;
      nreg_pkg::S_CP_WR: begin
        state_nxt = stat.idx_last ? nreg_pkg::S_DONE : nreg_pkg::S_CP_RD;
      end
      nreg_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_nxt = nreg_pkg::S_IDLE;
        end
      end
      default: state_nxt = nreg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      nreg_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      nreg_pkg::S_CHECK: begin
        cmd.res_clr = 1'b1;
        cmd.e_clr   = 1'b1;
        if (stat.req_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = nreg_pkg::STAT_BAD_REQ;
        end else if (stat.too_long) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = nreg_pkg::STAT_TOO_LONG;
        end
      end
      nreg_pkg::S_LEN_RD: cmd.rd_len = 1'b1;
      nreg_pkg::S_LEN_CHK: begin
        if (stat.len_eq) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.e_inc = 1'b1;
        end
      end
      nreg_pkg::S_CH_RD: cmd.rd_chars = 1'b1;
      nreg_pkg::S_CH_CHK: begin
        if (!stat.char_eq) begin
          cmd.e_inc = 1'b1;
        end else if (!stat.idx_last) begin
          cmd.idx_inc = 1'b1;
        end
      end
      nreg_pkg::S_HIT: begin
        if (stat.req_lookup) begin
          cmd.rd_id = 1'b1;
        end else begin
          cmd.wr_id_hit = 1'b1;
        end
      end
      nreg_pkg::S_ID_RD: ;
      nreg_pkg::S_ID_CHK: cmd.res_found_ld = 1'b1;
      nreg_pkg::S_MISS: begin
        if (stat.req_lookup) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = nreg_pkg::STAT_NOT_FOUND;
        end else if (stat.full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = nreg_pkg::STAT_FULL;
        end else begin
          cmd.idx_clr = 1'b1;
        end
      end
      nreg_pkg::S_CP_RD: cmd.rd_chars = 1'b1;
      nreg_pkg::S_CP_WR: begin
        cmd.wr_name = 1'b1;
        if (stat.idx_last) begin
          cmd.commit_new = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      nreg_pkg::S_DONE: begin
        cmd.out_load = stat.out_free;
        cmd.name_clr = stat.out_free;
      end
      default: ;
    endcase
  end

  a_accept_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (state_r == nreg_pkg::S_IDLE && !in_stall))
    else $error("request accepted outside idle");

  a_last_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_last_char) |=> (state_r == nreg_pkg::S_CHECK))
    else $error("final character did not start a search");

  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nreg_pkg::S_DONE && stat.out_free) |=> (state_r == nreg_pkg::S_IDLE))
    else $error("result hand-off did not return to idle");

endmodule

// ===== rtl/nreg_dp.sv =====
// ----------------------------------------------------------------------------
// Name registry datapath
// Incoming name buffer, entry tables, search counters and result register.
// ----------------------------------------------------------------------------
module nreg_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [nreg_pkg::REQ_W-1:0]          in_req_type,
  input  logic [nreg_pkg::CHAR_W-1:0]         in_name_char,
  input  logic [nreg_pkg::ID_W-1:0]           in_task_id,
  input  logic                                in_last_char,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [nreg_pkg::STATUS_W-1:0]       out_status,
  output logic [nreg_pkg::ID_W-1:0]           out_found_id,
  input  nreg_pkg::dp_cmd_t                   cmd,
  output nreg_pkg::dp_stat_t                  stat
);

  // storage
  logic [nreg_pkg::CHAR_W-1:0] inc_mem  [nreg_pkg::MAX_NAME_CHARS];
  logic [nreg_pkg::CHAR_W-1:0] name_mem [nreg_pkg::NAME_DEPTH];
  logic [nreg_pkg::LEN_W-1:0]  len_mem  [nreg_pkg::ENTRIES];
  logic [nreg_pkg::ID_W-1:0]   id_mem   [nreg_pkg::ENTRIES];

  logic [nreg_pkg::CHAR_W-1:0] inc_q;
  logic [nreg_pkg::CHAR_W-1:0] name_q;
  logic [nreg_pkg::LEN_W-1:0]  len_q;
  logic [nreg_pkg::ID_W-1:0]   id_q;

  logic [nreg_pkg::LEN_W-1:0]   len_r;
  logic                         too_long_r;
  logic [nreg_pkg::USED_W-1:0]  used_r;
  logic [nreg_pkg::ENTRY_W-1:0] e_r;
  logic [nreg_pkg::IDX_W-1:0]   idx_r;
  logic [nreg_pkg::REQ_W-1:0]   req_r;
  logic [nreg_pkg::ID_W-1:0]    id_r;
  nreg_pkg::status_t            res_status_r;
  logic [nreg_pkg::ID_W-1:0]    res_found_r;
  logic                         out_valid_r;
  logic [nreg_pkg::STATUS_W-1:0] out_status_r;
  logic [nreg_pkg::ID_W-1:0]    out_found_r;

  logic                         len_room;
  logic [nreg_pkg::ENTRY_W-1:0] new_slot;

  assign len_room = (len_r < nreg_pkg::LEN_W'(nreg_pkg::MAX_NAME_CHARS));
  assign new_slot = used_r[nreg_pkg::ENTRY_W-1:0];

  // collect characters of the incoming name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else if (cmd.name_clr) begin
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else if (cmd.accept) begin
      if (len_room) begin
        len_r <= len_r + nreg_pkg::LEN_W'(1);
      end else begin
        too_long_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && len_room) begin
      inc_mem[len_r[nreg_pkg::IDX_W-1:0]] <= in_name_char;
    end
    if (cmd.rd_chars) begin
      inc_q <= inc_mem[idx_r];
    end
  end

  // request fields from the final character
  always_ff @(posedge clk) begin
    if (cmd.accept && in_last_char) begin
      req_r <= in_req_type;
      id_r  <= in_task_id;
    end
  end

  // entry and character counters
  always_ff @(posedge clk) begin
    if (cmd.e_clr) begin
      e_r <= '0;
    end else if (cmd.e_inc) begin
      e_r <= e_r + nreg_pkg::ENTRY_W'(1);
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + nreg_pkg::IDX_W'(1);
    end
  end

  // entry tables
  always_ff @(posedge clk) begin
    if (cmd.rd_chars) begin
      name_q <= name_mem[{e_r, idx_r}];
    end
    if (cmd.wr_name) begin
      name_mem[{new_slot, idx_r}] <= inc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_len) begin
      len_q <= len_mem[e_r];
    end
    if (cmd.commit_new) begin
      len_mem[new_slot] <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_id) begin
      id_q <= id_mem[e_r];
    end
    if (cmd.wr_id_hit) begin
      id_mem[e_r] <= id_r;
    end else if (cmd.commit_new) begin
      id_mem[new_slot] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.commit_new) begin
      used_r <= used_r + nreg_pkg::USED_W'(1);
    end
  end

  // result being built
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
    end else if (cmd.res_clr) begin
      res_status_r <= nreg_pkg::STAT_OK;
    end
    if (cmd.res_found_ld) begin
      res_found_r <= id_q;
    end else if (cmd.res_clr) begin
      res_found_r <= '0;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found_id = out_found_r;

  assign stat.req_bad    = !(req_r inside {nreg_pkg::REQ_REGISTER, nreg_pkg::REQ_LOOKUP});
  assign stat.req_lookup = (req_r == nreg_pkg::REQ_LOOKUP);
  assign stat.too_long   = too_long_r;
  assign stat.used_zero  = (used_r == '0);
  assign stat.full       = (used_r == nreg_pkg::USED_W'(nreg_pkg::ENTRIES));
  assign stat.len_eq     = (len_q == len_r);
  assign stat.char_eq    = (name_q == inc_q);
  assign stat.idx_last   = ((nreg_pkg::LEN_W'(idx_r) + nreg_pkg::LEN_W'(1)) == len_r);
  assign stat.e_last     = ((nreg_pkg::USED_W'(e_r) + nreg_pkg::USED_W'(1)) == used_r);
  assign stat.out_free   = !out_valid_r || !out_stall;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= nreg_pkg::USED_W'(nreg_pkg::ENTRIES))
    else $error("entry count beyond table size");

  a_commit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_new |-> !stat.full)
    else $error("append into a full table");

  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_new |=> (used_r == $past(used_r) + nreg_pkg::USED_W'(1)))
    else $error("append did not advance entry count");

  a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !cmd.name_clr && !len_room) |=> too_long_r)
    else $error("overlong name not flagged");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a pending one");

endmodule

// ===== rtl/name_to_id_registry_table.sv =====
// ----------------------------------------------------------------------------
// Name to id registry table
// Character-serial name registry: register names with ids and look up ids by name.
// ----------------------------------------------------------------------------
// A request streams in one character per cycle, with no stall while the
// block is collecting. The final character (last mark set) starts the work
// and the input stalls until its result sits in the output register. Search
// runs over the single-port entry tables: the length of each stored entry
// is read and checked, and on a length match the name is read and compared
// one character at a time; appending a new name copies it one character at
// a time. A bad request type or overlong name skips the search. The table
// is empty after reset with no clearing pass.
module name_to_id_registry_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nreg_pkg::REQ_W-1:0]    in_req_type,
  input  logic [nreg_pkg::CHAR_W-1:0]   in_name_char,
  input  logic [nreg_pkg::ID_W-1:0]     in_task_id,
  input  logic                          in_last_char,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nreg_pkg::STATUS_W-1:0] out_status,
  output logic [nreg_pkg::ID_W-1:0]     out_found_id
);

  nreg_pkg::dp_cmd_t  cmd;
  nreg_pkg::dp_stat_t stat;

  nreg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  nreg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req_type  (in_req_type),
    .in_name_char (in_name_char),
    .in_task_id   (in_task_id),
    .in_last_char (in_last_char),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_found_id (out_found_id),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
